/* design/tfb_pkg.sv */
package tfb_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_NAME_LENGTH    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DATA_LENGTH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOAT_TYPE_CODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_TYPE_CODE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNSIGNED_TYPE_CODE = 3'd4;

  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [7:0]  SYNC_BYTE0       = 8'hA5;
  localparam logic [7:0]  SYNC_BYTE1       = 8'h5A;
  localparam logic [7:0]  FRAME_VERSION    = 8'h01;
  localparam logic [15:0] WORD_DATA_LENGTH = 16'd4;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_SYNC1,
    PH_VER,
    PH_TYPE,
    PH_SEQ,
    PH_NLEN,
    PH_DLO,
    PH_DHI,
    PH_PAY,
    PH_CRCLO,
    PH_CRCHI
  } phase_t;

  typedef struct packed {
    logic [7:0]  max_name_length;
    logic [15:0] max_data_length;
    logic [7:0]  float_type_code;
    logic [7:0]  signed_type_code;
    logic [7:0]  unsigned_type_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  message_type;
    logic [7:0]  name_length;
    logic [15:0] data_length;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       rejected;
  } result_t;

  // crc-16/ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* design/telemetry_frame_builder_crc16_unit.sv */
// Telemetry frame builder. Each input transaction carries one payload byte; on the
// first byte of a message the header fields are checked against the limits and
// word type codes in the configuration registers. A valid message produces the
// frame A5 5A 01 type seq name_length data_length_lo data_length_hi, then each
// payload byte as it arrives, then the CRC-16/CCITT-FALSE over everything from the
// version byte on, low byte first, with frame_end on the high byte. A bad header
// produces one transaction with rejected set and nothing else. The output emits one
// byte per cycle while out_stall is low: a payload byte in the middle of a message
// produces one frame byte, the first byte of a message produces nine (header plus
// byte), and the last payload byte is followed by the two CRC bytes. A reject gives
// one transaction. A single emit stage produces the frame bytes; in_stall is raised
// only while that stage is still busy with the previous byte's burst.
module telemetry_frame_builder_crc16_unit
  import tfb_pkg::*;
#(
  parameter logic [7:0]  NAME_LIMIT = 8'd32,
  parameter logic [15:0] DATA_LIMIT = 16'd256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             message_type,
  input  logic [7:0]             name_length,
  input  logic [15:0]            data_length,
  input  logic [7:0]             payload_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             frame_byte,
  output logic                   frame_end,
  output logic                   rejected
);

  cfg_t    cfg;
  item_t   in_item;
  result_t res;
  logic    emit;
  logic    ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_name_length    <= NAME_LIMIT;
      cfg.max_data_length    <= DATA_LIMIT;
      cfg.float_type_code    <= 8'd0;
      cfg.signed_type_code   <= 8'd1;
      cfg.unsigned_type_code <= 8'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_NAME_LENGTH:    cfg.max_name_length    <= cfg_data[7:0];
        REG_MAX_DATA_LENGTH:    cfg.max_data_length    <= cfg_data;
        REG_FLOAT_TYPE_CODE:    cfg.float_type_code    <= cfg_data[7:0];
        REG_SIGNED_TYPE_CODE:   cfg.signed_type_code   <= cfg_data[7:0];
        REG_UNSIGNED_TYPE_CODE: cfg.unsigned_type_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_item.message_type = message_type;
  assign in_item.name_length  = name_length;
  assign in_item.data_length  = data_length;
  assign in_item.payload_byte = payload_byte;

  tfb_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .ready    (ready),
    .emit     (emit),
    .res      (res)
  );

  tfb_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (emit),
    .load_data  (res),
    .ready      (ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .rejected   (rejected)
  );

endmodule

/* design/tfb_out_stage.sv */
module tfb_out_stage
  import tfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  input  result_t    load_data,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       frame_end,
  output logic       rejected
);

  result_t data;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && ready) begin
      data <= load_data;
    end
  end

  assign frame_byte = data.frame_byte;
  assign frame_end  = data.frame_end;
  assign rejected   = data.rejected;

endmodule

/* design/tfb_sequencer.sv */
module tfb_sequencer
  import tfb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    in_stall,
  input  logic    ready,
  output logic    emit,
  output result_t res
);

  logic        slot_valid;
  item_t       slot;
  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  sequence_number;
  logic [15:0] running_crc;
  logic [16:0] bytes_remaining;

  logic done;
  logic load;
  logic hdr_first;
  logic word_type;
  logic bad;
  logic feed_en;
  logic last_payload;

  assign emit      = slot_valid && ready;
  assign in_stall  = slot_valid && !(emit && done);
  assign load      = in_valid && !in_stall;
  assign hdr_first = (phase == PH_FIRST) && (bytes_remaining == 17'd0);

  assign word_type = (slot.message_type == cfg.float_type_code) ||
                     (slot.message_type == cfg.signed_type_code) ||
                     (slot.message_type == cfg.unsigned_type_code);
  assign bad = (slot.name_length == 8'd0) ||
               (slot.name_length > cfg.max_name_length) ||
               (slot.data_length > cfg.max_data_length) ||
               (word_type && (slot.data_length != WORD_DATA_LENGTH));

  assign last_payload = (bytes_remaining == 17'd1);

  // result byte of the current phase
  always_comb begin
    res     = '0;
    feed_en = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (hdr_first) begin
          if (bad) begin
            res.rejected = 1'b1;
          end else begin
            res.frame_byte = SYNC_BYTE0;
          end
        end else begin
          res.frame_byte = slot.payload_byte;
          feed_en        = 1'b1;
        end
      end
      PH_SYNC1: res.frame_byte = SYNC_BYTE1;
      PH_VER: begin
        res.frame_byte = FRAME_VERSION;
        feed_en        = 1'b1;
      end
      PH_TYPE: begin
        res.frame_byte = slot.message_type;
        feed_en        = 1'b1;
      end
      PH_SEQ: begin
        res.frame_byte = sequence_number;
        feed_en        = 1'b1;
      end
      PH_NLEN: begin
        res.frame_byte = slot.name_length;
        feed_en        = 1'b1;
      end
      PH_DLO: begin
        res.frame_byte = slot.data_length[7:0];
        feed_en        = 1'b1;
      end
      PH_DHI: begin
        res.frame_byte = slot.data_length[15:8];
        feed_en        = 1'b1;
      end
      PH_PAY: begin
        res.frame_byte = slot.payload_byte;
        feed_en        = 1'b1;
      end
      PH_CRCLO: res.frame_byte = running_crc[7:0];
      PH_CRCHI: begin
        res.frame_byte = running_crc[15:8];
        res.frame_end  = 1'b1;
      end
      default: res = '0;
    endcase
  end

  // next phase; done frees the slot for the next transaction
  always_comb begin
    phase_next = PH_FIRST;
    done       = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (hdr_first) begin
          if (bad) begin
            done = 1'b1;
          end else begin
            phase_next = PH_SYNC1;
          end
        end else if (last_payload) begin
          phase_next = PH_CRCLO;
        end else begin
          done = 1'b1;
        end
      end
      PH_SYNC1: phase_next = PH_VER;
      PH_VER:   phase_next = PH_TYPE;
      PH_TYPE:  phase_next = PH_SEQ;
      PH_SEQ:   phase_next = PH_NLEN;
      PH_NLEN:  phase_next = PH_DLO;
      PH_DLO:   phase_next = PH_DHI;
      PH_DHI:   phase_next = PH_PAY;
      PH_PAY: begin
        if (last_payload) begin
          phase_next = PH_CRCLO;
        end else begin
          done = 1'b1;
        end
      end
      PH_CRCLO: phase_next = PH_CRCHI;
      PH_CRCHI: done = 1'b1;
      default:  done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= 1'b0;
      phase           <= PH_FIRST;
      sequence_number <= 8'd0;
      running_crc     <= CRC_INIT;
      bytes_remaining <= 17'd0;
    end else begin
      if (load) begin
        slot_valid <= 1'b1;
      end else if (emit && done) begin
        slot_valid <= 1'b0;
      end
      if (emit) begin
        phase <= phase_next;
        if (hdr_first) begin
          if (!bad) begin
            running_crc     <= CRC_INIT;
            bytes_remaining <= {9'd0, slot.name_length} + {1'b0, slot.data_length};
          end
        end else if (feed_en) begin
          running_crc <= crc_feed(running_crc, res.frame_byte);
        end else if (phase == PH_CRCHI) begin
          running_crc <= CRC_INIT;
        end
        if (phase == PH_SEQ) begin
          sequence_number <= sequence_number + 8'd1;
        end
        if (phase == PH_PAY || (phase == PH_FIRST && !hdr_first)) begin
          bytes_remaining <= bytes_remaining - 17'd1;
        end
      end
    end
  end

  a_reject_frees_slot: assert property (@(posedge clk) disable iff (rst)
    emit && res.rejected |-> done && !res.frame_end)
    else $error("reject did not close the transaction");

  a_crc_pair: assert property (@(posedge clk) disable iff (rst)
    emit && phase == PH_CRCLO |=> slot_valid && phase == PH_CRCHI)
    else $error("crc low byte not followed by crc high byte");

  a_payload_pending: assert property (@(posedge clk) disable iff (rst)
    slot_valid && phase == PH_PAY |-> bytes_remaining != 17'd0)
    else $error("payload phase with no bytes remaining");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    emit && phase == PH_SEQ |=> sequence_number == $past(sequence_number) + 8'd1)
    else $error("sequence number did not step");

endmodule
